FILE: src/ttip_pkg.sv
// Shared types and constants of the text-to-integer parser.
// No dependencies; used by ttip_cfg, ttip_core and the top level.
package ttip_pkg;

  // APB register map
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam logic [1:0] REG_HEX_MODE    = 2'd0;
  localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
  localparam logic [1:0] REG_WIDE_MODE   = 2'd2;

  // Characters of interest
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_LO_X  = 8'h78;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Parser phase
  typedef enum logic [2:0] {
    PH_LEAD     = 3'd0,  // leading whitespace
    PH_BODY     = 3'd1,  // number body
    PH_HEX_BODY = 3'd2   // number body after a skipped 0x prefix
  } phase_e;

  typedef struct packed {
    logic hex_mode;
    logic signed_mode;
    logic wide_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_string;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic        valid_res;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Decode one character as a digit of the current base
  function automatic digit_t decode_digit(input logic [7:0] c, input logic hex);
    digit_t d;
    logic [7:0] off;
    d   = '0;
    off = '0;
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      off   = c - CHAR_ZERO;
      d.ok  = 1'b1;
      d.val = off[3:0];
    end else if (hex && (c inside {[CHAR_LO_A:CHAR_LO_F]})) begin
      off   = c - CHAR_LO_A + 8'd10;
      d.ok  = 1'b1;
      d.val = off[3:0];
    end else if (hex && (c inside {[CHAR_UP_A:CHAR_UP_F]})) begin
      off   = c - CHAR_UP_A + 8'd10;
      d.ok  = 1'b1;
      d.val = off[3:0];
    end
    return d;
  endfunction

  // C-locale whitespace: space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
  endfunction

  // Largest magnitude the target type allows for the given sign
  function automatic logic [63:0] limit_mag(input cfg_t cfg, input logic neg);
    logic [63:0] lim;
    if (!cfg.signed_mode) begin
      if (neg)                lim = 64'd0;
      else if (cfg.wide_mode) lim = {64{1'b1}};
      else                    lim = {32'd0, {32{1'b1}}};
    end else if (cfg.wide_mode) begin
      lim = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      lim = neg ? {32'd0, 1'b1, 31'd0} : {33'd0, {31{1'b1}}};
    end
    return lim;
  endfunction

endpackage

FILE: src/ttip_stage.sv
// Valid/ready register slice holding one transfer of any packed type.
// Depends on nothing; used for the input and result registers.
module ttip_stage #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic up_valid_i,
  output logic up_ready_o,
  input  T     up_data_i,
  output logic dn_valid_o,
  input  logic dn_ready_i,
  output T     dn_data_o
);

  logic valid_q;
  T     data_q;

  // free when empty or when the held transfer leaves this cycle
  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      data_q <= up_data_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

FILE: src/ttip_cfg.sv
// APB configuration registers: hex_mode, signed_mode, wide_mode.
// Depends on ttip_pkg for the register map and cfg_t.
module ttip_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttip_pkg::CfgAddrW-1:0] paddr,
  input  logic [ttip_pkg::CfgDataW-1:0] pwdata,
  output logic [ttip_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output ttip_pkg::cfg_t                cfg_o
);

  ttip_pkg::cfg_t cfg_q;
  logic [1:0]     idx;
  logic           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ttip_pkg::CfgAddrW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes; addresses past the map are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hex_mode    <= 1'b0;
      cfg_q.signed_mode <= 1'b1;
      cfg_q.wide_mode   <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        ttip_pkg::REG_HEX_MODE:    cfg_q.hex_mode    <= pwdata[0];
        ttip_pkg::REG_SIGNED_MODE: cfg_q.signed_mode <= pwdata[0];
        ttip_pkg::REG_WIDE_MODE:   cfg_q.wide_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      ttip_pkg::REG_HEX_MODE:    prdata = {{(ttip_pkg::CfgDataW-1){1'b0}}, cfg_q.hex_mode};
      ttip_pkg::REG_SIGNED_MODE: prdata = {{(ttip_pkg::CfgDataW-1){1'b0}}, cfg_q.signed_mode};
      ttip_pkg::REG_WIDE_MODE:   prdata = {{(ttip_pkg::CfgDataW-1){1'b0}}, cfg_q.wide_mode};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/ttip_core.sv
// Per-character parse step: string state registers and the digit
// accumulate / saturate logic. Depends on ttip_pkg.
module ttip_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ttip_pkg::cfg_t      cfg_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  ttip_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output ttip_pkg::out_item_t res_o
);

  ttip_pkg::phase_e phase_q, phase_s, phase_d;
  logic [63:0]      acc_q, acc_s, acc_d;
  logic             neg_q, neg_s, neg_d;
  logic             ws_q, ws_s, ws_d;
  logic             bad_q, bad_s, bad_d;
  logic [1:0]       dpos_q, dpos_s, dpos_d;
  logic             pend_q, pend_s, pend_d;

  logic [7:0]       c;
  logic             last, empty, str_end, fire, do_take;
  ttip_pkg::digit_t dig;
  logic [63:0]      lim;
  logic [68:0]      scaled, sum;
  logic             over;

  assign c       = item_i.char_code;
  assign last    = item_i.last_char;
  assign empty   = item_i.empty_string;
  assign str_end = last || empty;

  // a string's end needs room in the result register
  assign item_ready_o = !str_end || res_ready_i;
  assign res_valid_o  = item_valid_i && str_end;
  assign fire         = item_valid_i && item_ready_o;

  // acc * base + digit, kept exact so the limit test is a single compare
  assign dig    = ttip_pkg::decode_digit(c, cfg_i.hex_mode);
  assign lim    = ttip_pkg::limit_mag(cfg_i, neg_q);
  assign scaled = cfg_i.hex_mode ? {1'b0, acc_q, 4'd0}
                                 : ({2'b0, acc_q, 3'd0} + {4'b0, acc_q, 1'b0});
  assign sum    = scaled + {65'd0, dig.val};
  assign over   = sum > {5'd0, lim};

  // next string state for this character
  always_comb begin
    phase_s = phase_q;
    acc_s   = acc_q;
    neg_s   = neg_q;
    ws_s    = ws_q;
    bad_s   = bad_q;
    dpos_s  = dpos_q;
    pend_s  = pend_q;
    do_take = 1'b0;
    if (!bad_q) begin
      if (phase_q == ttip_pkg::PH_LEAD) begin
        if (ttip_pkg::is_space(c)) begin
          ws_s = 1'b1;
        end else if (c == ttip_pkg::CHAR_MINUS) begin
          neg_s   = 1'b1;
          phase_s = ttip_pkg::PH_BODY;
        end else if (c == ttip_pkg::CHAR_PLUS) begin
          phase_s = ttip_pkg::PH_BODY;
        end else begin
          phase_s = ttip_pkg::PH_BODY;
          do_take = 1'b1;
        end
      end else begin
        pend_s = 1'b0;
        if (pend_q && cfg_i.hex_mode && !last &&
            (c == ttip_pkg::CHAR_LO_X || c == ttip_pkg::CHAR_UP_X)) begin
          // skip the 0x prefix, drop the leading zero
          phase_s = ttip_pkg::PH_HEX_BODY;
          acc_s   = '0;
          dpos_s  = '0;
        end else begin
          do_take = 1'b1;
        end
      end
    end
    if (do_take) begin
      if (!dig.ok) begin
        bad_s = 1'b1;
      end else if (over) begin
        acc_s = lim;
        bad_s = 1'b1;
      end else begin
        acc_s = sum[63:0];
        // first body digit '0' in hex may open a prefix
        if (phase_q != ttip_pkg::PH_HEX_BODY && dpos_q == 2'd0 && cfg_i.hex_mode &&
            c == ttip_pkg::CHAR_ZERO && !last) begin
          pend_s = 1'b1;
        end
        if (dpos_q != 2'd2) begin
          dpos_s = dpos_q + 2'd1;
        end
      end
    end
  end

  // result of the string, taken when this character ends it
  always_comb begin
    if (empty) begin
      res_o.value     = '0;
      res_o.valid_res = 1'b0;
    end else begin
      res_o.value     = neg_s ? (64'd0 - acc_s) : acc_s;
      res_o.valid_res = !ws_s && !bad_s && (phase_s != ttip_pkg::PH_LEAD) &&
                        (dpos_s != 2'd0);
    end
  end

  // state clears at every string end
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    ws_d    = ws_q;
    bad_d   = bad_q;
    dpos_d  = dpos_q;
    pend_d  = pend_q;
    if (fire) begin
      if (str_end) begin
        phase_d = ttip_pkg::PH_LEAD;
        acc_d   = '0;
        neg_d   = 1'b0;
        ws_d    = 1'b0;
        bad_d   = 1'b0;
        dpos_d  = '0;
        pend_d  = 1'b0;
      end else begin
        phase_d = phase_s;
        acc_d   = acc_s;
        neg_d   = neg_s;
        ws_d    = ws_s;
        bad_d   = bad_s;
        dpos_d  = dpos_s;
        pend_d  = pend_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ttip_pkg::PH_LEAD;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      ws_q    <= 1'b0;
      bad_q   <= 1'b0;
      dpos_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      ws_q    <= ws_d;
      bad_q   <= bad_d;
      dpos_q  <= dpos_d;
      pend_q  <= pend_d;
    end
  end

endmodule

FILE: src/text_to_integer_parser_top.sv
// Text-to-integer parser: one ASCII character per transfer in, one result
// (64-bit value and valid flag) out on each string's last character or on
// an empty-string item. Every character is parsed during the cycle it spends
// in the input register, so a new character is taken every cycle unless a
// string's end must wait for room in the result register; the parse cycle is
// bounded by the 64-bit multiply-by-base, add and limit compare. A result is
// written into the result register as its last character is taken. A string's
// last character waits in the input register only while the result register
// holds a result that is not being taken in that cycle. Registers are set over
// APB: hex_mode at 0x0, signed_mode at 0x4, wide_mode at 0x8; write them only
// while no character or result is in flight.
// Depends on ttip_pkg, ttip_cfg, ttip_stage and ttip_core.
module text_to_integer_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ttip_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ttip_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttip_pkg::CfgAddrW-1:0] paddr,
  input  logic [ttip_pkg::CfgDataW-1:0] pwdata,
  output logic [ttip_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  ttip_pkg::cfg_t      cfg;
  logic                item_valid, item_ready;
  ttip_pkg::in_item_t  item;
  logic                res_valid, res_ready;
  ttip_pkg::out_item_t res;

  ttip_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  ttip_stage #(.T(ttip_pkg::in_item_t)) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .up_ready_o (in_ready_o),
    .up_data_i  (in_item_i),
    .dn_valid_o (item_valid),
    .dn_ready_i (item_ready),
    .dn_data_o  (item)
  );

  ttip_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // result register
  ttip_stage #(.T(ttip_pkg::out_item_t)) u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (res_valid),
    .up_ready_o (res_ready),
    .up_data_i  (res),
    .dn_valid_o (out_valid_o),
    .dn_ready_i (out_ready_i),
    .dn_data_o  (out_item_o)
  );

endmodule
